// ===== design/stt_pkg.sv =====
`timescale 1ns / 1ps
package stt_pkg;

    localparam int TableDepthDefault = 64;
    localparam logic [15:0] HalfLifeReset = 16'd10000;
    localparam logic [31:0] OneQ16 = 32'h0001_0000;
    localparam logic [31:0] TieMax = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ENCOUNTER = 2'd0,
        OP_MERGE     = 2'd1,
        OP_COMPARE   = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_DRAW    = 2'd1;
    localparam logic [1:0] ST_WINNER  = 2'd2;

    localparam logic CFG_OWN  = 1'b0;
    localparam logic CFG_HALF = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] peer_address;
        logic [31:0] second_address;
        logic [31:0] destination_address;
        logic [31:0] time_seconds;
        logic [31:0] tie_value_in;
        logic        last_of_merge;
    } stt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] winner_address;
        logic [31:0] tie_value_out;
    } stt_out_t;

    // queue entry handed from the front to the back
    typedef struct packed {
        stt_in_t     item;
        logic        merge_new;
    } stt_cmd_t;

    // 2^-(2^-(i+1)) in Q0.32, i = 0..15
    function automatic logic [31:0] root_const(input logic [3:0] i);
        logic [31:0] c;
        case (i)
            4'd0:    c = 32'hB504F333;
            4'd1:    c = 32'hD744FCCA;
            4'd2:    c = 32'hEAC0C6E7;
            4'd3:    c = 32'hF5257D15;
            4'd4:    c = 32'hFA83B2DB;
            4'd5:    c = 32'hFD3E0C0C;
            4'd6:    c = 32'hFE9E115C;
            4'd7:    c = 32'hFF4ECB59;
            4'd8:    c = 32'hFFA75652;
            4'd9:    c = 32'hFFD3A751;
            4'd10:   c = 32'hFFE9D2B2;
            4'd11:   c = 32'hFFF4E91B;
            4'd12:   c = 32'hFFFA747E;
            4'd13:   c = 32'hFFFD3A3A;
            4'd14:   c = 32'hFFFE9D1C;
            default: c = 32'hFFFF4E8D;
        endcase
        return c;
    endfunction

endpackage

// ===== design/social_tie_table_top.sv =====
`timescale 1ns / 1ps
// channel  | signals                         | transfer
// command  | start, busy, cmd                | start && !busy
// result   | done, result                    | done, one cycle, no back-pressure
// config   | cfg_we, cfg_index, cfg_data     | cfg_we
// an encounter whose two pairs are both known runs, for each pair in turn: a scan,
// then check, a 48-step divider, a power unit, scale and write, with a wait state
// between the halves; a scan reads one entry per cycle. a new pair skips the weight and goes straight to write.
// merge and compare run one scan, then check; done is registered from the done state.
// reset clears the count, the insert pointer and the merge window.
// busy is high while the two-entry queue is full; results cannot be held off.
module social_tie_table_top #(
    parameter int TABLE_DEPTH = stt_pkg::TableDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  stt_pkg::stt_in_t   cmd,
    output logic               done,
    output stt_pkg::stt_out_t  result,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import stt_pkg::*;

    logic [31:0] own_address_reg;
    logic [15:0] half_life_reg;
    logic        q_full, q_push, q_pop, q_ne, front_busy;
    stt_cmd_t    q_in, q_head;

    assign busy = front_busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            half_life_reg   <= HalfLifeReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_OWN)
            begin
                own_address_reg <= cfg_data;
            end
            else
            begin
                half_life_reg <= cfg_data[15:0];
            end
        end
    end

    stt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(cmd),
        .q_full(q_full), .q_push(q_push), .q_data(q_in), .front_busy(front_busy)
    );

    stt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in),
        .pop(q_pop), .full(q_full), .not_empty(q_ne), .head(q_head)
    );

    stt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .own_address(own_address_reg),
        .half_life_seconds(half_life_reg), .q_valid(q_ne), .q_head(q_head),
        .q_pop(q_pop), .done(done), .result(result)
    );
endmodule

// ===== design/stt_ram.sv =====
`timescale 1ns / 1ps
module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/stt_front.sv =====
`timescale 1ns / 1ps
module stt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  stt_pkg::stt_in_t   in_item,
    input  logic               q_full,
    output logic               q_push,
    output stt_pkg::stt_cmd_t  q_data,
    output logic               front_busy
);
    import stt_pkg::*;

    logic merge_open_reg;
    logic merge_open_next;

    assign front_busy = q_full;
    assign q_push     = start && !q_full;

    // classify merge items: the first one of a window opens a new base
    always_comb
    begin
        q_data.item      = in_item;
        q_data.merge_new = (in_item.operation == OP_MERGE) && !merge_open_reg;
        merge_open_next  = merge_open_reg;
        if (q_push && in_item.operation == OP_MERGE)
        begin
            merge_open_next = !in_item.last_of_merge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_open_reg <= 1'b0;
        end
        else
        begin
            merge_open_reg <= merge_open_next;
        end
    end
endmodule

// ===== design/stt_queue.sv =====
`timescale 1ns / 1ps
module stt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stt_pkg::stt_cmd_t  push_data,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output stt_pkg::stt_cmd_t  head
);
    import stt_pkg::*;

    // two-entry queue
    stt_cmd_t   slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       rd_reg;
    logic       wr_reg;

    assign full       = count_reg == 2'd2;
    assign not_empty  = count_reg != 2'd0;
    assign head       = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end
endmodule

// ===== design/stt_back.sv =====
`timescale 1ns / 1ps
module stt_back #(
    parameter int TABLE_DEPTH = stt_pkg::TableDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        own_address,
    input  logic [15:0]        half_life_seconds,
    input  logic               q_valid,
    input  stt_pkg::stt_cmd_t  q_head,
    output logic               q_pop,
    output logic               done,
    output stt_pkg::stt_out_t  result
);
    import stt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LastIndex = AW'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_WAIT, S_CHECK, S_DIV, S_POW, S_SCALE,
        S_WRITE, S_DONE
    } state_t;

    state_t        state_reg;
    stt_cmd_t      cmd_reg;
    logic          half_reg;          // second half of an encounter
    logic [CW-1:0] count_reg;
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] base_reg;
    logic [CW-1:0] limit_reg;
    logic [CW-1:0] idx_reg;           // scan issue index
    logic          rvalid_reg;
    logic [AW-1:0] ridx_reg;          // index of data on rdata
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic [31:0]   hit_stamp_reg;
    logic [31:0]   hit_tie_reg;
    logic [31:0]   tie_a_reg;
    logic [31:0]   tie_b_reg;
    logic [31:0]   key_a_reg;
    logic [31:0]   key_b_reg;
    logic [31:0]   own_tie_reg;
    logic [47:0]   quot_reg;          // elapsed * 65536 / half life
    logic [47:0]   rem_reg;
    logic [5:0]    step_reg;
    logic          grow_reg;
    logic [31:0]   pow_reg;           // Q0.32 fraction product
    logic          pow_one_reg;
    logic [15:0]   g_reg;
    logic [4:0]    bit_reg;
    logic [31:0]   wgt_reg;
    logic          done_reg;
    stt_out_t      res_reg;
    logic          we_reg;
    logic [AW-1:0] waddr_reg;
    logic [127:0]  wdata_reg;
    logic [AW-1:0] raddr;
    logic [127:0]  rdata;

    // one entry row: first, second, stamp, tie
    stt_ram #(.WIDTH(128), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (we_reg),
        .waddr (waddr_reg),
        .wdata (wdata_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign raddr     = idx_reg[AW-1:0];
    assign done      = done_reg;
    assign result    = res_reg;
    assign q_pop     = state_reg == S_IDLE && q_valid;

    logic [31:0] r_first, r_second, r_stamp, r_tie;
    assign r_first  = rdata[127:96];
    assign r_second = rdata[95:64];
    assign r_stamp  = rdata[63:32];
    assign r_tie    = rdata[31:0];

    logic [63:0] prod;
    logic [31:0] cst;
    logic [48:0] rem_sh;
    logic [32:0] sum_sat;
    logic [31:0] delta;
    logic [15:0] hl;
    logic [47:0] grown;
    logic [5:0]  nint;

    always_comb
    begin
        cst    = root_const(bit_reg[3:0]);
        prod   = pow_one_reg ? {cst, 32'd0} : 64'(pow_reg) * 64'(cst);
        rem_sh = {rem_reg, quot_reg[47]};
        hl     = (half_life_seconds == 16'd0) ? 16'd1 : half_life_seconds;
        delta  = (cmd_reg.item.time_seconds < hit_stamp_reg)
            ? hit_stamp_reg - cmd_reg.item.time_seconds
            : cmd_reg.item.time_seconds - hit_stamp_reg;
        sum_sat = {1'b0, hit_tie_reg} + {1'b0, wgt_reg};
        nint    = (quot_reg[47:22] != 26'd0) ? 6'd63 : quot_reg[21:16];
        grown   = 48'(pow_one_reg ? 33'h1_0000_0000 : {1'b0, pow_reg}) >> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            base_reg   <= '0;
            done_reg   <= 1'b0;
            we_reg     <= 1'b0;
            rvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            we_reg   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_head;
                        half_reg  <= 1'b0;
                        hit_reg   <= 1'b0;
                        tie_a_reg <= '0;
                        tie_b_reg <= '0;
                        idx_reg   <= '0;
                        rvalid_reg <= 1'b0;
                        unique case (op_t'(q_head.item.operation))
                            OP_ENCOUNTER:
                            begin
                                key_a_reg <= own_address;
                                key_b_reg <= q_head.item.peer_address;
                                limit_reg <= count_reg;
                                state_reg <= S_SCAN;
                            end
                            OP_MERGE:
                            begin
                                key_a_reg <= q_head.item.peer_address;
                                key_b_reg <= q_head.item.second_address;
                                limit_reg <= q_head.merge_new ? count_reg : base_reg;
                                if (q_head.merge_new)
                                begin
                                    base_reg <= count_reg;
                                end
                                state_reg <= S_SCAN;
                            end
                            OP_COMPARE:
                            begin
                                limit_reg <= count_reg;
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                // one entry per cycle; read data comes from the registered read of the issued address
                S_SCAN:
                begin
                    logic stop;
                    stop = 1'b0;
                    if (rvalid_reg)
                    begin
                        if (cmd_reg.item.operation == OP_COMPARE)
                        begin
                            if (r_second == cmd_reg.item.destination_address)
                            begin
                                if (r_first == cmd_reg.item.peer_address)
                                begin
                                    tie_a_reg <= r_tie;
                                    stop = r_tie != 0 && tie_b_reg != 0;
                                end
                                else if (r_first == cmd_reg.item.second_address)
                                begin
                                    tie_b_reg <= r_tie;
                                    stop = r_tie != 0 && tie_a_reg != 0;
                                end
                            end
                        end
                        else if (r_first == key_a_reg && r_second == key_b_reg)
                        begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= ridx_reg;
                            hit_stamp_reg <= r_stamp;
                            hit_tie_reg   <= r_tie;
                            stop = 1'b1;
                        end
                    end
                    if (stop || (idx_reg >= limit_reg && !rvalid_reg) ||
                        (idx_reg >= limit_reg && rvalid_reg &&
                         CW'(ridx_reg) + 1'b1 >= limit_reg))
                    begin
                        rvalid_reg <= 1'b0;
                        state_reg  <= S_CHECK;
                    end
                    else if (idx_reg < limit_reg)
                    begin
                        rvalid_reg <= 1'b1;
                        ridx_reg   <= idx_reg[AW-1:0];
                        idx_reg    <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        rvalid_reg <= 1'b0;
                    end
                end
                S_CHECK:
                begin
                    unique case (op_t'(cmd_reg.item.operation))
                        OP_COMPARE:
                        begin
                            res_reg.tie_value_out <= (tie_a_reg >= tie_b_reg)
                                ? tie_a_reg : tie_b_reg;
                            if (tie_a_reg == tie_b_reg)
                            begin
                                res_reg.status         <= ST_DRAW;
                                res_reg.winner_address <= '0;
                            end
                            else
                            begin
                                res_reg.status         <= ST_WINNER;
                                res_reg.winner_address <= (tie_a_reg > tie_b_reg)
                                    ? cmd_reg.item.peer_address
                                    : cmd_reg.item.second_address;
                            end
                            state_reg <= S_DONE;
                        end
                        OP_MERGE:
                        begin
                            res_reg.status         <= ST_UPDATED;
                            res_reg.winner_address <= '0;
                            if (hit_reg)
                            begin
                                if (cmd_reg.item.time_seconds > hit_stamp_reg)
                                begin
                                    we_reg    <= 1'b1;
                                    waddr_reg <= hit_idx_reg;
                                    wdata_reg <= {key_a_reg, key_b_reg,
                                        cmd_reg.item.time_seconds,
                                        cmd_reg.item.tie_value_in};
                                    res_reg.tie_value_out <= cmd_reg.item.tie_value_in;
                                end
                                else
                                begin
                                    res_reg.tie_value_out <= hit_tie_reg;
                                end
                            end
                            else
                            begin
                                we_reg <= 1'b1;
                                wdata_reg <= {key_a_reg, key_b_reg,
                                    cmd_reg.item.time_seconds,
                                    cmd_reg.item.tie_value_in};
                                res_reg.tie_value_out <= cmd_reg.item.tie_value_in;
                                if (count_reg < FullCount)
                                begin
                                    waddr_reg <= count_reg[AW-1:0];
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    waddr_reg <= ptr_reg;
                                    ptr_reg   <= (ptr_reg == LastIndex) ? '0
                                        : ptr_reg + 1'b1;
                                end
                            end
                            state_reg <= S_DONE;
                        end
                        default:
                        begin
                            if (hit_reg)
                            begin
                                // restoring divide of delta<<16 by half life
                                quot_reg  <= {delta, 16'd0};
                                rem_reg   <= '0;
                                step_reg  <= '0;
                                grow_reg  <= cmd_reg.item.time_seconds < hit_stamp_reg;
                                state_reg <= S_DIV;
                            end
                            else
                            begin
                                wgt_reg   <= OneQ16;
                                state_reg <= S_WRITE;
                            end
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (rem_sh >= 49'(hl))
                    begin
                        rem_reg  <= 48'(rem_sh - 49'(hl));
                        quot_reg <= {quot_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[47:0];
                        quot_reg <= {quot_reg[46:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd47)
                    begin
                        state_reg <= S_POW;
                        pow_one_reg <= 1'b1;
                        pow_reg  <= '0;
                        bit_reg  <= '0;
                        g_reg    <= '0;
                    end
                end
                S_POW:
                begin
                    // first cycle picks the exponent fraction
                    if (bit_reg == 5'd0 && g_reg == 16'd0 && pow_one_reg && !step_reg[0])
                    begin
                        step_reg[0] <= 1'b1;
                        if (!grow_reg)
                        begin
                            g_reg <= quot_reg[15:0];
                        end
                        else
                        begin
                            g_reg <= 16'(17'h10000 - {1'b0, quot_reg[15:0]});
                        end
                    end
                    else
                    begin
                        if (g_reg[15 - bit_reg[3:0]])
                        begin
                            pow_reg     <= prod[63:32];
                            pow_one_reg <= 1'b0;
                        end
                        bit_reg <= bit_reg + 1'b1;
                        if (bit_reg == 5'd15)
                        begin
                            state_reg <= S_SCALE;
                        end
                    end
                end
                S_SCALE:
                begin
                    if (!grow_reg)
                    begin
                        wgt_reg <= (nint >= 6'd48) ? '0 : 32'(
                            {pow_one_reg, pow_reg} >> (6'd16 + nint));
                    end
                    else if (nint >= 6'd16)
                    begin
                        wgt_reg <= TieMax;
                    end
                    else if (quot_reg[15:0] == 16'd0)
                    begin
                        wgt_reg <= OneQ16 << nint[3:0];
                    end
                    else if ((grown << (nint + 6'd1)) > 48'(TieMax))
                    begin
                        wgt_reg <= TieMax;
                    end
                    else
                    begin
                        wgt_reg <= 32'(grown << (nint + 6'd1));
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    logic [31:0] nt;
                    nt = hit_reg ? (sum_sat[32] ? TieMax : sum_sat[31:0]) : OneQ16;
                    we_reg    <= 1'b1;
                    wdata_reg <= {key_a_reg, key_b_reg, cmd_reg.item.time_seconds, nt};
                    if (hit_reg)
                    begin
                        waddr_reg <= hit_idx_reg;
                    end
                    else if (count_reg < FullCount)
                    begin
                        waddr_reg <= count_reg[AW-1:0];
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        waddr_reg <= ptr_reg;
                        ptr_reg   <= (ptr_reg == LastIndex) ? '0 : ptr_reg + 1'b1;
                    end
                    if (!half_reg)
                    begin
                        own_tie_reg <= nt;
                        half_reg    <= 1'b1;
                        key_a_reg   <= cmd_reg.item.peer_address;
                        key_b_reg   <= own_address;
                        hit_reg     <= 1'b0;
                        idx_reg     <= '0;
                        rvalid_reg  <= 1'b0;
                        limit_reg   <= (!hit_reg && count_reg < FullCount)
                            ? count_reg + 1'b1 : count_reg;
                        state_reg   <= S_WAIT;
                    end
                    else
                    begin
                        res_reg.status         <= ST_UPDATED;
                        res_reg.winner_address <= '0;
                        res_reg.tie_value_out  <= own_tie_reg;
                        state_reg <= S_DONE;
                    end
                end
                // let the first half's write land before rescanning
                S_WAIT:
                begin
                    state_reg <= S_SCAN;
                end
                default:
                begin
                    done_reg  <= 1'b1;
                    step_reg  <= '0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== design/stt_checker.sv =====
`timescale 1ns / 1ps
module stt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input stt_pkg::stt_out_t result
);
    import stt_pkg::*;

    // a result never carries the unused status code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status != 2'd3) else $error("bad status");

    // a draw or update has no winner
    a_nowin: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_WINNER |-> result.winner_address == 32'd0)
        else $error("winner on non-win");

    // done is a single-cycle pulse
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // nothing is busy straight out of reset
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !busy) else $error("busy after reset");

    // busy only rises after an accepted transaction fills the queue
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start)) else $error("busy rose without a transaction");
endmodule

bind social_tie_table_top stt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
